// ===== hw/rtl/lcdf_pkg.sv =====
// shared constants for the luminance cdf table
// field widths, rec.709 weights in q0.16 and command codes; no dependencies
package lcdf_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 4096;

  localparam int unsigned CH_W    = 16;  // q8.8 color channel
  localparam int unsigned LUM_W   = 16;  // q8.8 luminance
  localparam int unsigned TOTAL_W = 28;  // running prefix sum
  localparam int unsigned Q_W     = 16;  // q0.16 ratio
  localparam int unsigned IDX_W   = 12;  // entry_index port
  localparam int unsigned CMD_W   = 2;

  localparam logic [CH_W:0] W_RED   = 17'd13933;
  localparam logic [CH_W:0] W_GREEN = 17'd46871;
  localparam logic [CH_W:0] W_BLUE  = 17'd4732;

  localparam logic [Q_W-1:0] Q16_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LUM  = 4'b0010,
    S_RD   = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

endpackage

// ===== hw/rtl/luminance_cdf_table.sv =====
// luminance cdf table for importance sampling
// uses lcdf_pkg, lcdf_lum, lcdf_div and lcdf_store
//
// a request is taken at a clock edge with start high and busy low; cmd picks
// the operation. clear (cmd 0) takes effect at once and gives no result.
// load (cmd 1) runs the rgb channels through a bit-serial weighted sum, one
// bit per cycle, then commits luminance and prefix to the store; busy stays
// high until the commit. read (cmd 2) does one registered memory read, then
// two radix-2 dividers run side by side for 17 steps, busy until done is set.
// the divider step count sets the read rate, the channel width the load rate.
// a load into a full store or a read past the loaded entries gives an error
// result in the cycle after the request, and busy stays low. command 3 is
// dropped without a result.
// each result is on norm_luminance, cdf_value and error for one cycle with
// done high; the receiver cannot stall, so it must take it then.
// reset empties the frame; the memories are not cleared, and nothing can read
// an entry that was not loaded in the current frame.
module luminance_cdf_table
  import lcdf_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [CMD_W-1:0] cmd,
  input  logic [CH_W-1:0]  red,
  input  logic [CH_W-1:0]  green,
  input  logic [CH_W-1:0]  blue,
  input  logic [IDX_W-1:0] entry_index,
  output logic             done,
  output logic [Q_W-1:0]   norm_luminance,
  output logic [Q_W-1:0]   cdf_value,
  output logic             error
);

  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned XW = (CW > IDX_W) ? CW : IDX_W;

  state_t state;

  logic [CW-1:0]      pixel_count;
  logic [LUM_W-1:0]   peak_luminance;
  logic [TOTAL_W-1:0] running_total;
  logic               last_entry;

  logic               accept;
  logic               full;
  logic [XW-1:0]      idx_ext;
  logic [XW-1:0]      cnt_ext;
  logic               bad_index;
  logic               is_last;

  logic               lum_start, lum_valid;
  logic [LUM_W-1:0]   lum;
  logic [TOTAL_W:0]   sum_wide;
  logic [TOTAL_W-1:0] sum_sat;

  logic               store_we, store_re;
  logic [LUM_W-1:0]   rlum;
  logic [TOTAL_W-1:0] rprefix;

  logic               div_start;
  logic               norm_valid, cdf_valid;
  logic [Q_W-1:0]     norm_q, cdf_q;

  assign busy      = (state != S_IDLE);
  assign accept    = start && (state == S_IDLE);
  assign full      = (pixel_count == CW'(MAX_PIXELS));
  assign idx_ext   = XW'(entry_index);
  assign cnt_ext   = XW'(pixel_count);
  assign bad_index = (idx_ext >= cnt_ext);
  assign is_last   = ((idx_ext + XW'(1)) == cnt_ext);

  assign lum_start = accept && (cmd == CMD_LOAD) && !full;
  assign store_we  = (state == S_LUM) && lum_valid;
  assign store_re  = accept && (cmd == CMD_READ);
  assign div_start = (state == S_RD);

  // running total saturates at its full width
  assign sum_wide = {1'b0, running_total} + (TOTAL_W+1)'(lum);
  assign sum_sat  = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];

  lcdf_lum u_lum (
    .clk   (clk),
    .rst   (rst),
    .start (lum_start),
    .red   (red),
    .green (green),
    .blue  (blue),
    .valid (lum_valid),
    .lum   (lum)
  );

  lcdf_store #(
    .DEPTH (MAX_PIXELS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (store_we),
    .waddr   (pixel_count[AW-1:0]),
    .wlum    (lum),
    .wprefix (sum_sat),
    .re      (store_re),
    .raddr   (AW'(entry_index)),
    .rlum    (rlum),
    .rprefix (rprefix)
  );

  lcdf_div #(.W(LUM_W)) u_norm_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (rlum),
    .den   (peak_luminance),
    .valid (norm_valid),
    .quot  (norm_q)
  );

  lcdf_div #(.W(TOTAL_W)) u_cdf_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (rprefix),
    .den   (running_total),
    .valid (cdf_valid),
    .quot  (cdf_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      pixel_count    <= '0;
      peak_luminance <= '0;
      running_total  <= '0;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (cmd)
              CMD_CLEAR: begin
                pixel_count    <= '0;
                peak_luminance <= '0;
                running_total  <= '0;
              end
              CMD_LOAD: begin
                if (full) begin
                  done           <= 1'b1;
                  norm_luminance <= '0;
                  cdf_value      <= '0;
                  error          <= 1'b1;
                end else begin
                  state <= S_LUM;
                end
              end
              CMD_READ: begin
                if (bad_index) begin
                  done           <= 1'b1;
                  norm_luminance <= '0;
                  cdf_value      <= '0;
                  error          <= 1'b1;
                end else begin
                  last_entry <= is_last;
                  state      <= S_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_LUM: begin
          if (lum_valid) begin
            running_total <= sum_sat;
            if (lum > peak_luminance) peak_luminance <= lum;
            pixel_count <= pixel_count + 1'b1;
            state       <= S_IDLE;
          end
        end
        S_RD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (norm_valid) begin
            done           <= 1'b1;
            norm_luminance <= norm_q;
            cdf_value      <= last_entry ? Q16_MAX : cdf_q;
            error          <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pixel_count <= CW'(MAX_PIXELS))
    else $error("pixel count beyond store depth");

  a_dividers_together: assert property (@(posedge clk) disable iff (rst)
    norm_valid == cdf_valid)
    else $error("dividers out of step");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    norm_valid |-> (state == S_DIV))
    else $error("divider finished outside read");

  a_write_not_full: assert property (@(posedge clk) disable iff (rst)
    store_we |-> !full)
    else $error("store write while full");

  a_bad_read_error: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_READ) && bad_index) |=> (done && error && !busy))
    else $error("bad read index gave no error result");

  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    lum_start |=> (busy && !done))
    else $error("load request did not start work");

endmodule

// ===== hw/rtl/lcdf_lum.sv =====
// bit-serial rec.709 luminance: one bit of each channel per cycle, lsb first
// depends on lcdf_pkg for widths and weights
module lcdf_lum
  import lcdf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CH_W-1:0]  red,
  input  logic [CH_W-1:0]  green,
  input  logic [CH_W-1:0]  blue,
  output logic             valid,
  output logic [LUM_W-1:0] lum
);

  localparam int unsigned ACC_W = 2 * CH_W;
  localparam int unsigned CNT_W = $clog2(CH_W + 1);

  logic [CH_W-1:0]  red_sh, green_sh, blue_sh;
  logic [ACC_W-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [CH_W+1:0]  wsum;
  logic [ACC_W:0]   acc_next;

  // weights of the channels whose current bit is set
  always_comb begin
    wsum = '0;
    if (red_sh[0])   wsum = wsum + (CH_W+2)'(W_RED);
    if (green_sh[0]) wsum = wsum + (CH_W+2)'(W_GREEN);
    if (blue_sh[0])  wsum = wsum + (CH_W+2)'(W_BLUE);
    acc_next = {1'b0, acc} + {wsum[CH_W:0], {CH_W{1'b0}}};
  end

  assign valid = running && (cnt == '0);
  assign lum   = acc[ACC_W-1:CH_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running  <= 1'b1;
      cnt      <= CNT_W'(CH_W);
      acc      <= '0;
      red_sh   <= red;
      green_sh <= green;
      blue_sh  <= blue;
    end else if (running) begin
      if (cnt == '0) begin
        running <= 1'b0;
      end else begin
        cnt      <= cnt - 1'b1;
        acc      <= acc_next[ACC_W:1];
        red_sh   <= red_sh >> 1;
        green_sh <= green_sh >> 1;
        blue_sh  <= blue_sh >> 1;
      end
    end
  end

endmodule

// ===== hw/rtl/lcdf_div.sv =====
// radix-2 restoring divider for floor(num * 2^16 / den), saturated to q0.16
// expects num <= den; depends on lcdf_pkg
module lcdf_div
  import lcdf_pkg::*;
#(
  parameter int unsigned W = LUM_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   num,
  input  logic [W-1:0]   den,
  output logic           valid,
  output logic [Q_W-1:0] quot
);

  localparam int unsigned STEPS = Q_W + 1;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic [W:0]       rem;
  logic [W-1:0]     den_q;
  logic             den_zero;
  logic [Q_W:0]     qsh;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [W+1:0]     diff;
  logic             fits;
  logic [W-1:0]     rem_sub;

  always_comb begin
    diff    = {1'b0, rem} - {2'b00, den_q};
    fits    = !diff[W+1];
    rem_sub = fits ? diff[W-1:0] : rem[W-1:0];
  end

  assign valid = running && (cnt == '0);

  always_comb begin
    if (den_zero)     quot = '0;
    else if (qsh[Q_W]) quot = Q16_MAX;
    else              quot = qsh[Q_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running  <= 1'b1;
      cnt      <= CNT_W'(STEPS);
      rem      <= {1'b0, num};
      den_q    <= den;
      den_zero <= (den == '0);
      qsh      <= '0;
    end else if (running) begin
      if (cnt == '0) begin
        running <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
        qsh <= {qsh[Q_W-1:0], fits};
        rem <= {rem_sub, 1'b0};
      end
    end
  end

endmodule

// ===== hw/rtl/lcdf_store.sv =====
// luminance and prefix-sum memories, one write and one registered read port
// depends on lcdf_pkg for data widths
module lcdf_store
  import lcdf_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_PIXELS_DEF,
  parameter int unsigned AW    = 12
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [LUM_W-1:0]   wlum,
  input  logic [TOTAL_W-1:0] wprefix,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [LUM_W-1:0]   rlum,
  output logic [TOTAL_W-1:0] rprefix
);

  logic [LUM_W-1:0]   lum_mem    [DEPTH];
  logic [TOTAL_W-1:0] prefix_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      lum_mem[waddr]    <= wlum;
      prefix_mem[waddr] <= wprefix;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rlum    <= lum_mem[raddr];
      rprefix <= prefix_mem[raddr];
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for luminance_cdf_table: clear, load and read requests
// checked against an in-bench luminance/prefix table predictor; depends on lcdf_pkg
module tb_top;
  import lcdf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_DEPTH = MAX_PIXELS_DEF;
  localparam int unsigned LONG_FRAME = 40;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam bit [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct {
    logic [CMD_W-1:0] op;
    logic [CH_W-1:0]  r;
    logic [CH_W-1:0]  g;
    logic [CH_W-1:0]  b;
    logic [IDX_W-1:0] idx;
  } pixel_req_t;

  typedef struct {
    logic [Q_W-1:0] norm;
    logic [Q_W-1:0] cdf;
    logic           err;
  } entry_read_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [CMD_W-1:0] cmd = CMD_CLEAR;
  logic [CH_W-1:0]  red = '0;
  logic [CH_W-1:0]  green = '0;
  logic [CH_W-1:0]  blue = '0;
  logic [IDX_W-1:0] entry_index = '0;
  logic             busy;
  logic             done;
  logic [Q_W-1:0]   norm_luminance;
  logic [Q_W-1:0]   cdf_value;
  logic             error;

  luminance_cdf_table #(
    .MAX_PIXELS(STORE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .red(red),
    .green(green),
    .blue(blue),
    .entry_index(entry_index),
    .done(done),
    .norm_luminance(norm_luminance),
    .cdf_value(cdf_value),
    .error(error)
  );

  always #4 clk = ~clk;

  // predicted frame contents
  bit [LUM_W-1:0]   luma_mem [STORE_DEPTH];
  bit [TOTAL_W-1:0] prefix_mem [STORE_DEPTH];
  int unsigned      pix_cnt = 0;
  bit [LUM_W-1:0]   peak_luma = '0;
  bit [TOTAL_W-1:0] luma_total = '0;

  pixel_req_t  pending_reqs[$];
  entry_read_t due_reads[$];
  int          total_reqs = 0;
  int          accepted_cnt = 0;
  int          mismatches = 0;
  bit          req_taken = 1'b0;
  int          gap_left = 0;
  bit          steady = 1'b0;

  function automatic logic [Q_W-1:0] share_q16(input bit [TOTAL_W-1:0] part,
                                               input bit [TOTAL_W-1:0] whole);
    bit [TOTAL_W+15:0] q;
    if (whole == 0) return '0;
    q = {part, 16'h0000} / (TOTAL_W+16)'(whole);
    return (q > Q16_MAX) ? Q16_MAX : q[Q_W-1:0];
  endfunction

  // applies one request to the predicted frame; returns 1 when it yields a result
  function automatic bit step_luma_table(input logic [CMD_W-1:0] op,
                                         input logic [CH_W-1:0] r, g, b,
                                         input logic [IDX_W-1:0] idx,
                                         output entry_read_t res);
    bit [33:0]        wsum;
    bit [LUM_W-1:0]   lum;
    bit [TOTAL_W:0]   sum;
    res.norm = '0;
    res.cdf = '0;
    res.err = 1'b1;
    case (op)
      CMD_CLEAR: begin
        pix_cnt = 0;
        peak_luma = '0;
        luma_total = '0;
        return 1'b0;
      end
      CMD_LOAD: begin
        if (pix_cnt >= STORE_DEPTH) return 1'b1;
        wsum = 34'(W_RED) * 34'(r) + 34'(W_GREEN) * 34'(g) + 34'(W_BLUE) * 34'(b);
        lum = (wsum[33:16] > Q16_MAX) ? Q16_MAX : wsum[31:16];
        sum = (TOTAL_W+1)'(luma_total) + (TOTAL_W+1)'(lum);
        luma_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        luma_mem[pix_cnt] = lum;
        prefix_mem[pix_cnt] = luma_total;
        if (lum > peak_luma) peak_luma = lum;
        pix_cnt++;
        return 1'b0;
      end
      CMD_READ: begin
        if (idx >= pix_cnt) return 1'b1;
        res.err = 1'b0;
        res.norm = share_q16(TOTAL_W'(luma_mem[idx]), TOTAL_W'(peak_luma));
        // last loaded entry always reads full scale
        res.cdf = (idx + 1 == pix_cnt) ? Q16_MAX : share_q16(prefix_mem[idx], luma_total);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic add_req(input logic [CMD_W-1:0] op, input int unsigned r, g, b,
                         input int unsigned idx);
    pixel_req_t rq;
    rq.op = op;
    rq.r = CH_W'(r);
    rq.g = CH_W'(g);
    rq.b = CH_W'(b);
    rq.idx = IDX_W'(idx);
    pending_reqs = {pending_reqs, rq};
  endtask

  function automatic int unsigned rand_channel();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return 0;
    if (pick < 25) return 32'h0000_FFFF;
    if (pick < 40) return $urandom_range(0, 255);
    return $urandom_range(0, 65535);
  endfunction

  // driver: new request at the falling edge once the previous one was taken, after any random gap
  always @(negedge clk) begin : driver
    pixel_req_t nxt;
    int pick;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      req_taken = 1'b0;
      if ($urandom_range(0, 63) == 0) steady = !steady;
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs.pop_front();
        cmd <= nxt.op;
        red <= nxt.r;
        green <= nxt.g;
        blue <= nxt.b;
        entry_index <= nxt.idx;
        start <= 1'b1;
        pick = $urandom_range(0, 99);
        if (steady || pick < 50) gap_left = 0;
        else if (pick < 90) gap_left = $urandom_range(1, 3);
        else gap_left = $urandom_range(4, 40);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: checks results, then records the request taken at this edge
  always @(posedge clk) begin : monitor
    entry_read_t want;
    if (!rst) begin
      if (done) begin
        if (due_reads.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: norm %0d cdf %0d error %0d",
                     norm_luminance, cdf_value, error);
        end else begin
          want = due_reads.pop_front();
          if (want.norm !== norm_luminance || want.cdf !== cdf_value ||
              want.err !== error) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: expected norm %0d cdf %0d error %0d, ",
                        "got norm %0d cdf %0d error %0d"},
                       want.norm, want.cdf, want.err, norm_luminance, cdf_value, error);
          end
        end
      end
      if (start && !busy) begin
        req_taken = 1'b1;
        accepted_cnt++;
        if (step_luma_table(cmd, red, green, blue, entry_index, want))
          due_reads = {due_reads, want};
      end
    end
  end

  initial begin : stimulus
    int cnt;
    int sel;
    int left;
    int ops;

    // empty frame, ignored command, all-zero pixels
    add_req(CMD_READ, $urandom, $urandom, $urandom, 0);
    add_req(CMD_READ, $urandom, $urandom, $urandom, STORE_DEPTH - 1);
    add_req(CMD_NONE, $urandom, $urandom, $urandom, $urandom);
    add_req(CMD_LOAD, 0, 0, 0, $urandom);
    add_req(CMD_READ, $urandom, $urandom, $urandom, 0);
    add_req(CMD_LOAD, 0, 0, 0, $urandom);
    add_req(CMD_READ, $urandom, $urandom, $urandom, 0);
    add_req(CMD_READ, $urandom, $urandom, $urandom, 1);
    add_req(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
    // channel extremes, each weight on its own
    add_req(CMD_LOAD, '1, '1, '1, $urandom);
    add_req(CMD_LOAD, '1, 0, 0, $urandom);
    add_req(CMD_LOAD, 0, '1, 0, $urandom);
    add_req(CMD_LOAD, 0, 0, '1, $urandom);
    add_req(CMD_LOAD, 1, 1, 1, $urandom);
    for (int k = 0; k < 5; k++) add_req(CMD_READ, $urandom, $urandom, $urandom, k);
    add_req(CMD_READ, $urandom, $urandom, $urandom, 5);
    add_req(CMD_READ, $urandom, $urandom, $urandom, STORE_DEPTH - 1);
    add_req(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
    add_req(CMD_READ, $urandom, $urandom, $urandom, 0);

    // a longer frame, then reads across it and just past its end
    add_req(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
    for (int k = 0; k < LONG_FRAME; k++)
      add_req(CMD_LOAD, rand_channel(), rand_channel(), rand_channel(), $urandom);
    add_req(CMD_LOAD, '1, '1, '1, $urandom);
    add_req(CMD_READ, $urandom, $urandom, $urandom, LONG_FRAME);
    add_req(CMD_READ, $urandom, $urandom, $urandom, LONG_FRAME - 1);
    add_req(CMD_READ, $urandom, $urandom, $urandom, 0);
    add_req(CMD_READ, $urandom, $urandom, $urandom, LONG_FRAME + 1);
    repeat (8) add_req(CMD_READ, $urandom, $urandom, $urandom,
                       $urandom_range(0, LONG_FRAME));
    add_req(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
    add_req(CMD_LOAD, rand_channel(), rand_channel(), rand_channel(), $urandom);
    add_req(CMD_READ, $urandom, $urandom, $urandom, 0);

    // random frames: mostly loads and in-range reads, some noise
    left = 320;
    while (left > 0) begin
      add_req(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
      left--;
      cnt = 0;
      ops = $urandom_range(5, 60);
      repeat (ops) begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          add_req(CMD_LOAD, rand_channel(), rand_channel(), rand_channel(), $urandom);
          cnt++;
        end else if (sel < 80 && cnt > 0) begin
          add_req(CMD_READ, $urandom, $urandom, $urandom, $urandom_range(0, cnt - 1));
        end else if (sel < 88 && cnt > 0) begin
          add_req(CMD_READ, $urandom, $urandom, $urandom, cnt - 1);
        end else if (sel < 95) begin
          add_req(CMD_READ, $urandom, $urandom, $urandom,
                  $urandom_range(cnt, STORE_DEPTH - 1));
        end else if (sel < 98) begin
          add_req(CMD_NONE, $urandom, $urandom, $urandom, $urandom);
        end else begin
          // frame cut short
          add_req(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
          cnt = 0;
        end
        left--;
      end
    end
    total_reqs = pending_reqs.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted_cnt < total_reqs) @(posedge clk);
    while (due_reads.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lcdf_pkg.sv
hw/rtl/lcdf_lum.sv
hw/rtl/lcdf_div.sv
hw/rtl/lcdf_store.sv
hw/rtl/luminance_cdf_table.sv
tb/tb_top.sv
